// ----- hw/rtl/bat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocation table package
// Sizes, request codes, sequencer states and the formatted entry contents.
// ----------------------------------------------------------------------------
package bat_pkg;

  localparam int ENTRIES    = 1024;
  localparam int RESERVED   = 8;
  localparam int ADDR_W     = $clog2(ENTRIES);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int BLOCK_W    = 10;
  localparam int LINK_W     = 11;
  localparam int ENTRY_W    = LINK_W + 1;
  localparam int SCAN_START = (RESERVED < ENTRIES) ? RESERVED : ENTRIES;

  localparam logic [LINK_W-1:0] LINK_END = '1;

  typedef enum logic [2:0] {
    MODE_FORMAT    = 3'd0,
    MODE_GET_NEXT  = 3'd1,
    MODE_SET_NEXT  = 3'd2,
    MODE_FIND_FREE = 3'd3,
    MODE_ALLOCATE  = 3'd4,
    MODE_FREE      = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FORMAT,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Entry layout: bit LINK_W is the in-use flag, the bits below are the link.
  function automatic logic [ENTRY_W-1:0] fmt_entry(input logic [ADDR_W-1:0] idx);
    logic [ENTRY_W-1:0] e;
    e = {1'b0, LINK_END};
    if (int'(idx) < RESERVED) begin
      e[LINK_W] = 1'b1;
      if ((int'(idx) + 1 < RESERVED) && (int'(idx) + 1 < ENTRIES)) begin
        e[LINK_W-1:0] = LINK_W'(int'(idx) + 1);
      end
    end
    return e;
  endfunction

  function automatic logic block_ok(input logic [BLOCK_W-1:0] blk);
    return int'(blk) < ENTRIES;
  endfunction

endpackage

// ----- hw/rtl/block_allocation_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocation table
// Each request takes one item and returns one item. The table sits in a
// single-port-write, registered-read memory of ENTRIES words, each holding an
// in-use flag and an 11-bit link. Get next, set next and allocate pass through
// the check and done states and free goes straight to done, where the result
// is handed to the output register. Find first free walks the memory one entry
// per cycle from the first non-reserved block, up to the end of the table.
// Format rewrites one entry per cycle over the whole table, and after reset
// the same sweep covers all ENTRIES words before the first item is accepted.
// The memory port is the limit in every case, and ready is low while a
// request is in progress.
// ----------------------------------------------------------------------------
module block_allocation_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mode[2:0], block[12:3], next_block[23:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // value[10:0], status[11], end_of_chain[12]
);

  localparam int ADDR_W  = bat_pkg::ADDR_W;
  localparam int PTR_W   = bat_pkg::PTR_W;
  localparam int LINK_W  = bat_pkg::LINK_W;
  localparam int ENTRY_W = bat_pkg::ENTRY_W;
  localparam int BLOCK_W = bat_pkg::BLOCK_W;

  bat_pkg::state_t state_r, state_nxt;
  bat_pkg::mode_t  mode_r, mode_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic [LINK_W-1:0]  nblk_r, nblk_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic               chk_v_r, chk_v_nxt;

  logic [LINK_W-1:0]  res_value_r, res_value_nxt;
  logic               res_status_r, res_status_nxt;
  logic               res_eoc_r, res_eoc_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LINK_W-1:0]  out_value_r, out_value_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_eoc_r, out_eoc_nxt;

  logic [ENTRY_W-1:0] mem [bat_pkg::ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  logic               in_accept;
  bat_pkg::mode_t     in_mode;
  logic [BLOCK_W-1:0] in_block;
  logic [LINK_W-1:0]  in_next;
  logic               sweep_last;
  logic               scan_found;
  logic               scan_end;
  logic               out_free;

  assign in_mode    = bat_pkg::mode_t'(in_tdata[2:0]);
  assign in_block   = in_tdata[12:3];
  assign in_next    = in_tdata[23:13];
  assign in_tready  = (state_r == bat_pkg::ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign sweep_last = (ptr_r == PTR_W'(bat_pkg::ENTRIES - 1));
  assign scan_found = chk_v_r && !rd_data_r[LINK_W];
  assign scan_end   = (ptr_r == PTR_W'(bat_pkg::ENTRIES));
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_eoc_r, out_status_r, out_value_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bat_pkg::ST_CLEAR: begin
        if (sweep_last) begin
          state_nxt = bat_pkg::ST_IDLE;
        end
      end
      bat_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_mode)
            bat_pkg::MODE_FORMAT:    state_nxt = bat_pkg::ST_FORMAT;
            bat_pkg::MODE_GET_NEXT,
            bat_pkg::MODE_SET_NEXT,
            bat_pkg::MODE_ALLOCATE:  state_nxt = bat_pkg::ST_CHECK;
            bat_pkg::MODE_FIND_FREE: state_nxt = bat_pkg::ST_SCAN;
            default:                 state_nxt = bat_pkg::ST_DONE;
          endcase
        end
      end
      bat_pkg::ST_FORMAT: begin
        if (sweep_last) begin
          state_nxt = bat_pkg::ST_DONE;
        end
      end
      bat_pkg::ST_CHECK: state_nxt = bat_pkg::ST_DONE;
      bat_pkg::ST_SCAN: begin
        if (scan_found || scan_end) begin
          state_nxt = bat_pkg::ST_DONE;
        end
      end
      bat_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bat_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    mode_nxt       = mode_r;
    blk_nxt        = blk_r;
    nblk_nxt       = nblk_r;
    ptr_nxt        = ptr_r;
    chk_v_nxt      = chk_v_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_eoc_nxt    = res_eoc_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_eoc_nxt    = out_eoc_r;
    mem_we         = 1'b0;
    mem_waddr      = ADDR_W'(blk_r);
    mem_wdata      = {1'b0, bat_pkg::LINK_END};
    mem_raddr      = ADDR_W'(blk_r);
    case (state_r)
      bat_pkg::ST_CLEAR, bat_pkg::ST_FORMAT: begin
        mem_we        = 1'b1;
        mem_waddr     = ptr_r[ADDR_W-1:0];
        mem_wdata     = bat_pkg::fmt_entry(ptr_r[ADDR_W-1:0]);
        ptr_nxt       = ptr_r + PTR_W'(1);
        res_value_nxt = LINK_W'(bat_pkg::RESERVED);
      end
      bat_pkg::ST_IDLE: begin
        mem_raddr = ADDR_W'(in_block);
        if (in_accept) begin
          mode_nxt       = in_mode;
          blk_nxt        = in_block;
          nblk_nxt       = in_next;
          res_value_nxt  = '0;
          res_status_nxt = 1'b0;
          res_eoc_nxt    = 1'b0;
          ptr_nxt        = '0;
          chk_v_nxt      = 1'b0;
          if (in_mode == bat_pkg::MODE_FIND_FREE) begin
            ptr_nxt = PTR_W'(bat_pkg::SCAN_START);
          end
          if (in_mode == bat_pkg::MODE_FREE) begin
            mem_we    = bat_pkg::block_ok(in_block);
            mem_waddr = ADDR_W'(in_block);
          end
        end
      end
      bat_pkg::ST_CHECK: begin
        case (mode_r)
          bat_pkg::MODE_GET_NEXT: begin
            if (bat_pkg::block_ok(blk_r)) begin
              res_value_nxt = rd_data_r[LINK_W-1:0];
              res_eoc_nxt   = (rd_data_r[LINK_W-1:0] == bat_pkg::LINK_END);
            end else begin
              res_value_nxt = bat_pkg::LINK_END;
              res_eoc_nxt   = 1'b1;
            end
          end
          bat_pkg::MODE_SET_NEXT: begin
            mem_we    = bat_pkg::block_ok(blk_r);
            mem_wdata = {rd_data_r[LINK_W], nblk_r};
          end
          bat_pkg::MODE_ALLOCATE: begin
            if (bat_pkg::block_ok(blk_r) && !rd_data_r[LINK_W]) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, bat_pkg::LINK_END};
            end else begin
              res_status_nxt = 1'b1;
            end
          end
          default: res_status_nxt = 1'b0;
        endcase
      end
      bat_pkg::ST_SCAN: begin
        mem_raddr = ptr_r[ADDR_W-1:0];
        if (scan_found) begin
          res_value_nxt = LINK_W'(ptr_r - PTR_W'(1));
        end else if (scan_end) begin
          res_value_nxt = bat_pkg::LINK_END;
        end else begin
          ptr_nxt   = ptr_r + PTR_W'(1);
          chk_v_nxt = 1'b1;
        end
      end
      bat_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_eoc_nxt    = res_eoc_r;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bat_pkg::ST_CLEAR;
      ptr_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    blk_r        <= blk_nxt;
    nblk_r       <= nblk_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_eoc_r    <= res_eoc_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_eoc_r    <= out_eoc_nxt;
  end

  a_accept_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("ready stayed high after an item was accepted");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(state_r == bat_pkg::ST_DONE))
    else $error("result presented without a completed request");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bat_pkg::ST_SCAN) |-> (ptr_r <= PTR_W'(bat_pkg::ENTRIES)))
    else $error("free-block scan ran past the table");

  a_no_write_idle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bat_pkg::ST_SCAN || state_r == bat_pkg::ST_DONE) |-> !mem_we)
    else $error("table written while scanning or handing off a result");

endmodule

// ----- tb/block_allocation_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocation table testbench
// Sends requests over the input stream with random idle cycles on both sides.
// Each result is predicted from a behavioural copy of the table or taken from
// the directed table, and every output item is checked in order. A directed
// table opens the run. The table is then filled to the top to reach the
// empty-scan case, and random chain-building traffic with occasional formats follows.
// ----------------------------------------------------------------------------
module block_allocation_table_test;

  localparam int ENTRIES  = bat_pkg::ENTRIES;
  localparam int RESERVED = bat_pkg::RESERVED;
  localparam int LINK_W   = bat_pkg::LINK_W;
  localparam int BLOCK_W  = bat_pkg::BLOCK_W;

  localparam int STALL_LIMIT  = 10000;
  localparam int RANDOM_ITEMS = 900;
  localparam int MAX_REPORTS  = 10;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [LINK_W-1:0]  next_block;
    logic [BLOCK_W-1:0] block;
    logic [2:0]         mode;
  } request_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic              end_of_chain;
    logic              status;
    logic [LINK_W-1:0] value;
  } result_t;

  typedef struct {
    logic [2:0] mode;
    int         blk;
    int         link;
    bit         typed;
    int         value;
    bit         status;
    bit         eoc;
  } row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;

  bit                in_use_map [ENTRIES];
  logic [LINK_W-1:0] link_map [ENTRIES];
  result_t           awaited_results [$];
  result_t           last_result;
  int                counted     = 0;
  int                mismatches  = 0;
  int                idle_cycles = 0;
  bit                steady      = 1'b0;

  row_t directed_rows [26] = '{
    '{bat_pkg::MODE_GET_NEXT,  0,    0,    1'b1, 1,        1'b0, 1'b0},
    '{bat_pkg::MODE_GET_NEXT,  7,    0,    1'b1, -1,       1'b0, 1'b1},
    '{bat_pkg::MODE_GET_NEXT,  1023, 1023, 1'b1, -1,       1'b0, 1'b1},
    '{bat_pkg::MODE_FIND_FREE, 0,    0,    1'b1, RESERVED, 1'b0, 1'b0},
    '{bat_pkg::MODE_ALLOCATE,  7,    0,    1'b1, 0,        1'b1, 1'b0},
    '{bat_pkg::MODE_ALLOCATE,  8,    0,    1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_ALLOCATE,  8,    0,    1'b1, 0,        1'b1, 1'b0},
    '{bat_pkg::MODE_FIND_FREE, 1023, -1,   1'b1, 9,        1'b0, 1'b0},
    '{bat_pkg::MODE_SET_NEXT,  8,    1023, 1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_GET_NEXT,  8,    0,    1'b1, 1023,     1'b0, 1'b0},
    '{bat_pkg::MODE_ALLOCATE,  1023, 0,    1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_SET_NEXT,  1023, -1,   1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_GET_NEXT,  1023, 0,    1'b1, -1,       1'b0, 1'b1},
    '{bat_pkg::MODE_SET_NEXT,  0,    0,    1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_GET_NEXT,  0,    0,    1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_SET_NEXT,  5,    682,  1'b0, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_GET_NEXT,  5,    341,  1'b0, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_FREE,      8,    0,    1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_GET_NEXT,  8,    0,    1'b1, -1,       1'b0, 1'b1},
    '{bat_pkg::MODE_FREE,      3,    0,    1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_FIND_FREE, 0,    0,    1'b1, RESERVED, 1'b0, 1'b0},
    '{MODE_SPARE_A,            5,    100,  1'b1, 0,        1'b0, 1'b0},
    '{MODE_SPARE_B,            1023, -1,   1'b1, 0,        1'b0, 1'b0},
    '{bat_pkg::MODE_FORMAT,    1023, -1,   1'b1, RESERVED, 1'b0, 1'b0},
    '{bat_pkg::MODE_GET_NEXT,  3,    0,    1'b1, 4,        1'b0, 1'b0},
    '{bat_pkg::MODE_ALLOCATE,  3,    0,    1'b1, 0,        1'b1, 1'b0}
  };

  block_allocation_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic reformat();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      in_use_map[i] = (i < RESERVED);
      link_map[i]   = (i + 1 < RESERVED) ? LINK_W'(i + 1) : bat_pkg::LINK_END;
    end
  endtask

  task automatic serve_request(input request_t r, output result_t res);
    int i;
    bit present;
    res     = '0;
    present = int'(r.block) < ENTRIES;
    case (r.mode)
      bat_pkg::MODE_FORMAT: begin
        reformat();
        res.value = LINK_W'(RESERVED);
      end
      bat_pkg::MODE_GET_NEXT: begin
        res.value        = present ? link_map[r.block] : bat_pkg::LINK_END;
        res.end_of_chain = (res.value == bat_pkg::LINK_END);
      end
      bat_pkg::MODE_SET_NEXT: begin
        if (present) link_map[r.block] = r.next_block;
      end
      bat_pkg::MODE_FIND_FREE: begin
        res.value = bat_pkg::LINK_END;
        for (i = RESERVED; i < ENTRIES && res.value == bat_pkg::LINK_END; i++) begin
          if (!in_use_map[i]) res.value = LINK_W'(i);
        end
      end
      bat_pkg::MODE_ALLOCATE: begin
        if (present && !in_use_map[r.block]) begin
          in_use_map[r.block] = 1'b1;
          link_map[r.block]   = bat_pkg::LINK_END;
        end else begin
          res.status = 1'b1;
        end
      end
      bat_pkg::MODE_FREE: begin
        if (present) begin
          in_use_map[r.block] = 1'b0;
          link_map[r.block]   = bat_pkg::LINK_END;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_request(input request_t r, input bit typed, input result_t due);
    result_t predicted;
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    serve_request(r, predicted);
    last_result = predicted;
    awaited_results.push_back(typed ? due : predicted);
    if (r.mode <= bat_pkg::MODE_FREE) counted++;
  endtask

  task automatic issue(input logic [2:0] mode, input int blk, input int link);
    request_t r;
    r.mode       = mode;
    r.block      = BLOCK_W'(blk);
    r.next_block = LINK_W'(link);
    push_request(r, 1'b0, '0);
  endtask

  task automatic settle();
    if (awaited_results.size() != 0) begin
      in_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
    end
  endtask

  function automatic int pick_block();
    if ($urandom_range(0, 99) < 60) return $urandom_range(RESERVED, RESERVED + 55);
    return $urandom_range(0, ENTRIES - 1);
  endfunction

  function automatic int pick_link();
    if ($urandom_range(0, 99) < 15) return -1;
    return $urandom_range(0, ENTRIES - 1);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    got = out_tdata;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result item %h at %0t", out_tdata, $time);
        end
      end else begin
        want = awaited_results.pop_front();
        if (got.value !== want.value || got.status !== want.status ||
            got.end_of_chain !== want.end_of_chain) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: expected value %0d status %0b end %0b,",
                     $time, $signed(want.value), want.status, want.end_of_chain,
                     " got value %0d status %0b end %0b",
                     $signed(got.value), got.status, got.end_of_chain);
          end
        end
      end
    end
    out_tready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int i;
    int n;
    int k;
    int chain_blocks [6];
    request_t r;
    result_t due;
    reformat();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < $size(directed_rows); i++) begin
      r.mode             = directed_rows[i].mode;
      r.block            = BLOCK_W'(directed_rows[i].blk);
      r.next_block       = LINK_W'(directed_rows[i].link);
      due                = '0;
      due.value          = LINK_W'(directed_rows[i].value);
      due.status         = directed_rows[i].status;
      due.end_of_chain   = directed_rows[i].eoc;
      push_request(r, directed_rows[i].typed, due);
    end
    settle();

    // Fill every free entry so that the scan finds nothing.
    issue(bat_pkg::MODE_FORMAT, 0, -1);
    steady = 1'b1;
    for (i = RESERVED; i < ENTRIES; i++) issue(bat_pkg::MODE_ALLOCATE, i, pick_link());
    steady = 1'b0;
    issue(bat_pkg::MODE_FIND_FREE, pick_block(), pick_link());
    issue(bat_pkg::MODE_FREE, $urandom_range(RESERVED, ENTRIES - 1), pick_link());
    issue(bat_pkg::MODE_FIND_FREE, pick_block(), pick_link());
    issue(bat_pkg::MODE_ALLOCATE, int'(last_result.value), pick_link());
    issue(bat_pkg::MODE_FIND_FREE, pick_block(), pick_link());
    issue(bat_pkg::MODE_FORMAT, pick_block(), pick_link());

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 35) begin
        n = $urandom_range(2, 6);
        for (i = 0; i < n; i++) begin
          chain_blocks[i] = pick_block();
          issue(bat_pkg::MODE_ALLOCATE, chain_blocks[i], pick_link());
        end
        for (i = 0; i < n; i++) begin
          issue(bat_pkg::MODE_SET_NEXT, chain_blocks[i],
                (i == n - 1) ? -1 : chain_blocks[i + 1]);
        end
        for (i = 0; i < n; i++) issue(bat_pkg::MODE_GET_NEXT, chain_blocks[i], pick_link());
        if ($urandom_range(0, 1) == 1) begin
          for (i = 0; i < n; i++) issue(bat_pkg::MODE_FREE, chain_blocks[i], pick_link());
        end
      end else if (k < 50) begin
        issue(bat_pkg::MODE_FIND_FREE, pick_block(), pick_link());
        if (last_result.value != bat_pkg::LINK_END) begin
          issue(bat_pkg::MODE_ALLOCATE, int'(last_result.value), pick_link());
        end
      end else if (k < 60) begin
        issue(bat_pkg::MODE_GET_NEXT, pick_block(), pick_link());
      end else if (k < 70) begin
        issue(bat_pkg::MODE_SET_NEXT, pick_block(), pick_link());
      end else if (k < 80) begin
        issue(bat_pkg::MODE_FREE, pick_block(), pick_link());
      end else if (k < 90) begin
        issue(bat_pkg::MODE_ALLOCATE, pick_block(), pick_link());
      end else if (k < 92) begin
        issue(bat_pkg::MODE_FORMAT, pick_block(), pick_link());
      end else if (k < 97) begin
        issue(($urandom_range(0, 1) == 1) ? MODE_SPARE_A : MODE_SPARE_B,
              pick_block(), pick_link());
      end else begin
        settle();
      end
    end

    settle();
    in_tvalid <= 1'b0;
    repeat (64) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/bat_pkg.sv
hw/rtl/block_allocation_table.sv
tb/block_allocation_table_test.sv
